[hw/rtl/chte_pkg.sv]
package chte_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int ENTRIES_DEF = 256;
    localparam int BCNT_W      = 9;
    localparam logic [BCNT_W-1:0] BCNT_RESET = 9'd256;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_CYCLES  = KEY_W / DIV_STEPS;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic             success;
        logic [VAL_W-1:0] value_out;
        logic             pool_full;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_HCAP, ST_CHK, ST_ECMP,
        ST_ACT, ST_POP, ST_ALLOC, ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic head_rd;
        logic head_cap;
        logic walk_rd;
        logic walk_cmp;
        logic pop_rd;
        logic alloc;
        logic unlink;
        logic set_res;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic cur_null;
        logic key_match;
        logic hit;
        logic pool_empty;
        logic out_free;
        t_op  op;
    } t_sts;

    function automatic logic [KEY_W-1:0] mix_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k ^ (k >> 20) ^ (k >> 12);
        return h ^ (h >> 7) ^ (h >> 4);
    endfunction

endpackage

[hw/rtl/chte_ram.sv]
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/chte_mod.sv]
module chte_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [chte_pkg::KEY_W-1:0]   i_dividend,
    input  logic [chte_pkg::BCNT_W-1:0]  i_modulus,
    output logic                         o_busy,
    output logic [chte_pkg::BCNT_W-1:0]  o_rem
);
    localparam int CW = $clog2(chte_pkg::DIV_CYCLES);

    logic                         r_busy;
    logic [CW-1:0]                r_cnt;
    logic [chte_pkg::KEY_W-1:0]   r_q, n_q;
    logic [chte_pkg::BCNT_W-1:0]  r_rem, n_rem;

    // restoring division, DIV_STEPS quotient bits per cycle; only the remainder is kept
    always_comb begin
        logic [chte_pkg::BCNT_W:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int i = 0; i < chte_pkg::DIV_STEPS; i++) begin
            t   = {n_rem, n_q[chte_pkg::KEY_W-1]};
            n_q = {n_q[chte_pkg::KEY_W-2:0], 1'b0};
            if (t >= {1'b0, i_modulus}) begin
                t = t - {1'b0, i_modulus};
            end
            n_rem = t[chte_pkg::BCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(chte_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule

[hw/rtl/chte_ctrl.sv]
module chte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  chte_pkg::t_sts i_sts,
    output chte_pkg::t_cmd o_cmd
);
    chte_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chte_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            chte_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = chte_pkg::ST_IDLE;
                end
            end
            chte_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = chte_pkg::ST_DIV;
                end
            end
            chte_pkg::ST_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = chte_pkg::ST_HCAP;
                end
            end
            chte_pkg::ST_HCAP: begin
                o_cmd.head_cap = 1'b1;
                n_state        = chte_pkg::ST_CHK;
            end
            chte_pkg::ST_CHK: begin
                if (i_sts.cur_null) begin
                    n_state = chte_pkg::ST_ACT;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state       = chte_pkg::ST_ECMP;
                end
            end
            chte_pkg::ST_ECMP: begin
                o_cmd.walk_cmp = 1'b1;
                n_state = i_sts.key_match ? chte_pkg::ST_ACT : chte_pkg::ST_CHK;
            end
            chte_pkg::ST_ACT: begin
                if (i_sts.op == chte_pkg::OP_INSERT && !i_sts.hit && !i_sts.pool_empty) begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = chte_pkg::ST_POP;
                end else begin
                    o_cmd.unlink  = (i_sts.op == chte_pkg::OP_REMOVE) && i_sts.hit;
                    o_cmd.set_res = 1'b1;
                    n_state       = chte_pkg::ST_DONE;
                end
            end
            chte_pkg::ST_POP: begin
                n_state = chte_pkg::ST_ALLOC;
            end
            chte_pkg::ST_ALLOC: begin
                o_cmd.alloc   = 1'b1;
                o_cmd.set_res = 1'b1;
                n_state       = chte_pkg::ST_DONE;
            end
            chte_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = chte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = chte_pkg::ST_CLEAR;
            end
        endcase
    end
endmodule

[hw/rtl/chte_dp.sv]
module chte_dp #(
    parameter int BUCKETS = chte_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chte_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  chte_pkg::t_cmd              i_cmd,
    output chte_pkg::t_sts              o_sts,
    input  chte_pkg::t_req              i_req,
    input  logic                        i_cfg_valid,
    input  logic [chte_pkg::BCNT_W-1:0] i_cfg_data,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    output chte_pkg::t_rsp              o_rsp
);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int EW = $clog2(ENTRIES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

    logic [chte_pkg::BCNT_W-1:0] r_bcnt, eff_n, rem;
    chte_pkg::t_op               r_op;
    logic [chte_pkg::KEY_W-1:0]  r_key;
    logic [chte_pkg::VAL_W-1:0]  r_vin, r_val;
    logic                        r_hit;
    logic [LW-1:0]               r_head, r_cur, r_prev, r_link, r_top, r_low;
    logic [BW-1:0]               r_clr, bkt;
    logic                        r_ovalid;
    chte_pkg::t_rsp              r_res, r_orsp, res;
    logic                        div_busy, prev_null, out_free, fresh;
    logic [LW-1:0]               pop_pos;
    logic [EW-1:0]               pop_addr, alloc_e, fs_rdata;
    logic [LW-1:0]               head_rdata, link_rdata, head_wdata, link_wdata;
    logic [EW-1:0]               link_waddr;
    logic [BW-1:0]               head_waddr;
    logic [chte_pkg::KEY_W-1:0]  key_rdata;
    logic [chte_pkg::VAL_W-1:0]  val_rdata;

    always_comb begin
        if (r_bcnt == '0) begin
            eff_n = chte_pkg::BCNT_W'(1);
        end else if (32'(r_bcnt) > BUCKETS) begin
            eff_n = chte_pkg::BCNT_W'(BUCKETS);
        end else begin
            eff_n = r_bcnt;
        end
    end

    chte_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.accept),
        .i_dividend (chte_pkg::mix_key(i_req.key)),
        .i_modulus  (eff_n),
        .o_busy     (div_busy),
        .o_rem      (rem)
    );

    assign bkt       = BW'(rem);
    assign prev_null = (r_prev >= NULL_LINK);
    assign pop_pos   = r_top - 1'b1;
    assign pop_addr  = pop_pos[EW-1:0];
    assign fresh     = (pop_pos < r_low);
    // stack slots below the low-water mark were never pushed: their entry index is derived from the slot position
    assign alloc_e   = fresh ? (EW'(ENTRIES - 1) - pop_addr) : fs_rdata;
    assign out_free  = !r_ovalid || !i_rsp_stall;

    assign head_waddr = i_cmd.clr_wr ? r_clr : bkt;
    assign head_wdata = i_cmd.clr_wr ? NULL_LINK : (i_cmd.alloc ? LW'(alloc_e) : r_link);
    assign link_waddr = i_cmd.alloc ? alloc_e : r_prev[EW-1:0];
    assign link_wdata = i_cmd.alloc ? r_head : r_link;

    chte_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(i_cmd.clr_wr || i_cmd.alloc || (i_cmd.unlink && prev_null)),
        .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_re(i_cmd.head_rd), .i_raddr(bkt), .o_rdata(head_rdata)
    );

    chte_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_links (
        .i_clk(i_clk), .i_we(i_cmd.alloc || (i_cmd.unlink && !prev_null)),
        .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_re(i_cmd.walk_rd), .i_raddr(r_cur[EW-1:0]), .o_rdata(link_rdata)
    );

    chte_ram #(.WIDTH(chte_pkg::KEY_W), .DEPTH(ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(i_cmd.alloc), .i_waddr(alloc_e), .i_wdata(r_key),
        .i_re(i_cmd.walk_rd), .i_raddr(r_cur[EW-1:0]), .o_rdata(key_rdata)
    );

    chte_ram #(.WIDTH(chte_pkg::VAL_W), .DEPTH(ENTRIES)) u_vals (
        .i_clk(i_clk), .i_we(i_cmd.alloc), .i_waddr(alloc_e), .i_wdata(r_vin),
        .i_re(i_cmd.walk_rd), .i_raddr(r_cur[EW-1:0]), .o_rdata(val_rdata)
    );

    chte_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (
        .i_clk(i_clk), .i_we(i_cmd.unlink), .i_waddr(r_top[EW-1:0]),
        .i_wdata(r_cur[EW-1:0]),
        .i_re(i_cmd.pop_rd), .i_raddr(pop_addr), .o_rdata(fs_rdata)
    );

    always_comb begin
        res = '0;
        case (r_op)
            chte_pkg::OP_INSERT: begin
                res.success   = !r_hit && (r_top != '0);
                res.pool_full = !r_hit && (r_top == '0);
            end
            chte_pkg::OP_REMOVE: begin
                res.success = r_hit;
            end
            chte_pkg::OP_LOOKUP: begin
                res.success   = r_hit;
                res.value_out = r_hit ? r_val : '0;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt   <= chte_pkg::BCNT_RESET;
            r_top    <= LW'(ENTRIES);
            r_low    <= LW'(ENTRIES);
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bcnt <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.alloc) begin
                r_top <= pop_pos;
                if (fresh) begin
                    r_low <= pop_pos;
                end
            end else if (i_cmd.unlink && r_top < LW'(ENTRIES)) begin
                r_top <= r_top + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request payload and chain walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= chte_pkg::t_op'(i_req.req_type);
            r_key <= i_req.key;
            r_vin <= i_req.value_in;
            r_hit <= 1'b0;
        end
        if (i_cmd.head_cap) begin
            r_head <= head_rdata;
            r_cur  <= head_rdata;
            r_prev <= NULL_LINK;
        end
        if (i_cmd.walk_cmp) begin
            if (key_rdata == r_key) begin
                r_hit  <= 1'b1;
                r_link <= link_rdata;
                r_val  <= val_rdata;
            end else begin
                r_prev <= r_cur;
                r_cur  <= link_rdata;
            end
        end
        if (i_cmd.set_res) begin
            r_res <= res;
        end
        if (i_cmd.load_out) begin
            r_orsp <= r_res;
        end
    end

    assign o_sts.clr_done   = (r_clr == BW'(BUCKETS - 1));
    assign o_sts.div_busy   = div_busy;
    assign o_sts.cur_null   = (r_cur >= NULL_LINK);
    assign o_sts.key_match  = (key_rdata == r_key);
    assign o_sts.hit        = r_hit;
    assign o_sts.pool_empty = (r_top == '0);
    assign o_sts.out_free   = out_free;
    assign o_sts.op         = r_op;

    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_orsp;
endmodule

[hw/rtl/chained_hash_table_engine_unit.sv]
// Channel   Direction  Handshake                 Payload
// req       in         i_req_valid / o_req_stall  chte_pkg::t_req  i_req
// rsp       out        o_rsp_valid / i_rsp_stall  chte_pkg::t_rsp  o_rsp
// cfg       in         i_cfg_valid / o_cfg_ready  bucket_count     i_cfg_data
//
// One request at a time, accept to next accept: the key modulo, a registered bucket head
// read, the chain walk until the key is found or the chain ends, and for an insert that
// allocates a pop from the free stack. The key modulo holds the request (4 dividend bits
// per cycle) and each chain step is a registered memory read and a compare.
// After reset the bucket heads are swept to empty, with o_req_stall high.
// A finished result waits in the output register; the next request is taken meanwhile.
module chained_hash_table_engine_unit #(
    parameter int BUCKETS = chte_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chte_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_stall,
    input  chte_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    output chte_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [chte_pkg::BCNT_W-1:0] i_cfg_data
);
    chte_pkg::t_cmd cmd;
    chte_pkg::t_sts sts;
    logic           req_ready;

    chte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    chte_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    assign o_req_stall = !req_ready;
    assign o_cfg_ready = 1'b1;
endmodule

[hw/rtl/chte_checker.sv]
module chte_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_stall,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input chte_pkg::t_rsp o_rsp
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response dropped or changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request taken while one is in flight");

    a_full_only_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.success && o_rsp.pool_full))
        else $error("pool_full on a successful result");

    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.value_out != '0) |-> o_rsp.success && !o_rsp.pool_full)
        else $error("value returned without a hit");
endmodule

bind chained_hash_table_engine_unit chte_checker u_chk (.*);
